// ===== src/spq_pkg.sv =====
// Package with format codes and conversion functions for the storage precision quantizer.
package spq_pkg;

    typedef enum logic [1:0] {
        FMT_PASS = 2'd0,
        FMT_HALF = 2'd1,
        FMT_BF16 = 2'd2,
        FMT_RSVD = 2'd3
    } fmt_t;

    localparam int VALUE_W  = 32;
    localparam int NARROW_W = 16;

    localparam logic [15:0] HALF_QNAN = 16'h7e00;
    localparam logic [15:0] HALF_INF  = 16'h7c00;

    // Single to half: round half away from zero, flush tiny values, overflow to infinity.
    function automatic logic [15:0] to_half(input logic [31:0] bits);
        logic [15:0] sign;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [8:0]  hexp;
        logic [23:0] norm;
        logic [4:0]  sh;
        logic [24:0] sum;
        logic [23:0] rounded;
        logic [15:0] res;
        sign = {bits[31], 15'd0};
        expo = bits[30:23];
        mant = bits[22:0];
        hexp = {1'b0, expo} - 9'd112;
        norm = {1'b1, mant};
        sh = 5'd0;
        sum = 25'd0;
        rounded = {1'b0, mant} + 24'h1000;
        if (expo == 8'hff) begin
            res = sign | ((mant != 23'd0) ? HALF_QNAN : HALF_INF);
        end else if (expo >= 8'd143) begin
            res = sign | HALF_INF;
        end else if (expo <= 8'd112) begin
            if (expo < 8'd102) begin
                res = sign;
            end else begin
                sh = 5'(8'd126 - expo);
                sum = {1'b0, norm} + (25'd1 << (sh - 5'd1));
                res = sign | 16'(sum >> sh);
            end
        end else if (rounded[23]) begin
            if (expo == 8'd142) begin
                res = sign | HALF_INF;
            end else begin
                res = sign | {1'b0, 5'(hexp + 9'd1), 10'd0};
            end
        end else begin
            res = sign | {1'b0, hexp[4:0], rounded[22:13]};
        end
        return res;
    endfunction

    // Half to single, with half subnormals normalized.
    function automatic logic [31:0] from_half(input logic [15:0] h);
        logic [4:0]  expo;
        logic [9:0]  mant;
        logic [3:0]  lz;
        logic [10:0] shifted;
        logic [31:0] res;
        expo = h[14:10];
        mant = h[9:0];
        lz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (mant[i]) begin
                lz = 4'(9 - i);
            end
        end
        shifted = {1'b0, mant} << (lz + 4'd1);
        if (expo == 5'd0) begin
            if (mant == 10'd0) begin
                res = {h[15], 31'd0};
            end else begin
                res = {h[15], 8'(8'd113 - 8'(lz) - 8'd1), shifted[9:0], 13'd0};
            end
        end else if (expo == 5'd31) begin
            res = {h[15], 8'hff, mant, 13'd0};
        end else begin
            res = {h[15], 8'(expo) + 8'd112, mant, 13'd0};
        end
        return res;
    endfunction

endpackage

// ===== src/spq_stream_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink (input valid, input value_bits, output ready);
endinterface

interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] quantized_bits;
    logic [15:0] narrow_bits;
    modport source (output valid, output quantized_bits, output narrow_bits, input ready);
    modport sink (input valid, input quantized_bits, input narrow_bits, output ready);
endinterface

interface spq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/storage_precision_quantizer.sv =====
// Top level of the storage precision quantizer: fp32 to fp16/bf16 round trip.
// The block accepts one single-precision word per cycle while results are
// taken and returns it rounded to the storage format in the configuration
// register (0 passthrough, 1 half, 2 bfloat16, 3 treated as passthrough),
// re-expanded to single precision, plus the 16-bit encoding. Each item is held
// in an input register and converted by combinational logic into a result
// register, which loads when it is empty or its result is taken, and is then
// valid. Throughput is one item per cycle while results are taken. The result
// register drains while the input register holds; the block stalls only when
// both are full and the result is not taken.
module storage_precision_quantizer (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch,
    spq_cfg_if.sink   cfg
);
    import spq_pkg::*;

    logic [1:0]  fmt_reg;
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    logic [31:0] q_reg;
    logic [15:0] n_reg;
    logic [31:0] q_next;
    logic [15:0] n_next;
    logic [31:0] bf_sum;
    logic        advance;

    assign cfg.ready = 1'b1;

    // The result register loads whenever it is empty or being taken.
    assign advance   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;

    assign bf_sum = in_data_reg + 32'h7fff + {31'd0, in_data_reg[16]};

    always_comb
    begin
        q_next = in_data_reg;
        n_next = 16'd0;
        case (fmt_t'(fmt_reg))
            FMT_BF16:
            begin
                q_next = bf_sum & 32'hffff0000;
                n_next = bf_sum[31:16];
            end
            FMT_HALF:
            begin
                n_next = to_half(in_data_reg);
                q_next = from_half(n_next);
            end
            default:
            begin
                q_next = in_data_reg;
                n_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_PASS;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                fmt_reg <= cfg.data;
            end
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_data_reg <= in_ch.value_bits;
        end
        if (advance && in_valid_reg)
        begin
            q_reg <= q_next;
            n_reg <= n_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.quantized_bits = q_reg;
    assign out_ch.narrow_bits    = n_reg;

    // A stalled result must not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(q_reg))
        else $error("result changed while stalled");

    // A pending item in the input register is never dropped.
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost");

    // Passthrough results carry a zero narrow encoding.
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && fmt_reg == FMT_PASS |=> n_reg == 16'd0)
        else $error("nonzero narrow bits in passthrough");

endmodule

// ===== tb/sv/spq_tb_scoreboard.sv =====
// Scoreboard class that predicts quantized results and checks them in order.
class spq_quant_scoreboard;
    typedef struct packed {
        logic [31:0] quantized;
        logic [15:0] narrow;
    } quant_result_t;

    spq_pkg::fmt_t  format;
    quant_result_t  pending[$];
    int             mismatches;

    function new();
        format = spq_pkg::FMT_PASS;
        mismatches = 0;
    endfunction

    // Rounds a single-precision word to half: half away from zero in magnitude.
    function logic [15:0] single_to_half(logic [31:0] word);
        logic [15:0] sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        int          hex;
        int          sh;
        logic [31:0] norm;
        logic [31:0] rnd;
        sgn = {word[31], 15'd0};
        ex = word[30:23];
        man = word[22:0];
        if (ex == 8'hff)
            return sgn | ((man != 0) ? spq_pkg::HALF_QNAN : spq_pkg::HALF_INF);
        hex = int'(ex) - 112;
        if (hex >= 31)
            return sgn | spq_pkg::HALF_INF;
        if (hex <= 0) begin
            if (hex < -10)
                return sgn;
            norm = {9'd0, man} | 32'h0080_0000;
            sh = 14 - hex;
            rnd = (norm + (32'd1 << (sh - 1))) >> sh;
            return sgn | rnd[15:0];
        end
        rnd = {9'd0, man} + 32'h1000;
        if (rnd[23]) begin
            if (hex + 1 >= 31)
                return sgn | spq_pkg::HALF_INF;
            return sgn | 16'((hex + 1) << 10);
        end
        return sgn | 16'(hex << 10) | 16'(rnd >> 13);
    endfunction

    // Expands a half word to single precision, normalizing half subnormals.
    function logic [31:0] half_to_single(logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [10:0] man;
        int          shift_count;
        sgn = {h[15], 31'd0};
        ex = h[14:10];
        man = {1'b0, h[9:0]};
        shift_count = 0;
        if (ex == 0) begin
            if (man == 0)
                return sgn;
            while (!man[10]) begin
                man = man << 1;
                shift_count++;
            end
            return sgn | (32'(113 - shift_count) << 23) | (32'(man[9:0]) << 13);
        end
        if (ex == 5'd31)
            return sgn | 32'h7f80_0000 | (32'(man[9:0]) << 13);
        return sgn | (32'(ex + 112) << 23) | (32'(man[9:0]) << 13);
    endfunction

    function void note_input(logic [31:0] word);
        quant_result_t r;
        logic [31:0]   sum;
        r.quantized = word;
        r.narrow = 16'd0;
        if (format == spq_pkg::FMT_BF16) begin
            sum = word + 32'h7fff + {31'd0, word[16]};
            r.quantized = sum & 32'hffff_0000;
            r.narrow = r.quantized[31:16];
        end else if (format == spq_pkg::FMT_HALF) begin
            r.narrow = single_to_half(word);
            r.quantized = half_to_single(r.narrow);
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] quantized, logic [15:0] narrow);
        quant_result_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result q=%h n=%h", quantized, narrow);
            return;
        end
        e = pending.pop_front();
        if (e.quantized !== quantized || e.narrow !== narrow) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected q=%h n=%h, got q=%h n=%h",
                         e.quantized, e.narrow, quantized, narrow);
        end
    endfunction
endclass

// ===== tb/sv/tb.sv =====
// Top-level testbench for the storage precision quantizer.
module tb;
    import spq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spq_in_if  in_ch();
    spq_out_if out_ch();
    spq_cfg_if cfg();

    storage_precision_quantizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    always #5 clk = ~clk;

    localparam int STALL_LIMIT = 2000;

    spq_quant_scoreboard quant_board = new();
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  timed_out = 1'b0;

    // The receiver stalls at random except during the no-gap stretch.
    always @(negedge clk) begin
        if (no_gaps)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= 29);
    end

    // Results are checked at the rising edge on which the transfer happens.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            quant_board.check_result(out_ch.quantized_bits, out_ch.narrow_bits);
    end

    // Watchdog: counts cycles in which no transfer happens on any channel.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drives one word, with a random gap beforehand unless the no-gap stretch is on.
    // Valid stays high after the transfer; the next word or a drain sets it.
    task automatic send_word(input logic [31:0] word);
        while (!no_gaps && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value_bits <= word;
        do @(posedge clk); while (!in_ch.ready);
        quant_board.note_input(word);
        @(negedge clk);
    endtask

    // Drops valid, then waits until every expected result has arrived plus the
    // pipeline drain time.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (quant_board.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The format register is only written while the block is idle.
    task automatic write_format(input fmt_t fmt);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= fmt;
        do @(posedge clk); while (!cfg.ready);
        quant_board.format = fmt;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Random word biased toward half exponent boundaries, specials and half/bf16 ties.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(5))
            0: w[30:23] = 8'($urandom_range(98, 145));
            1: w[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
            2: w[15:0] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            3: w[12:0] = $urandom_range(1) ? 13'h1000 : 13'h0fff;
            default: ;
        endcase
        return w;
    endfunction

    // Directed words: zeros, extremes, rounding ties, overflow, tiny values, NaN.
    logic [31:0] edge_words[] = '{
        32'h0000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7f80_0000, 32'hff80_0000,
        32'h7fc0_0001, 32'h7f80_0001, 32'h7fff_8000, 32'h0000_0001, 32'h3f80_8000,
        32'h3f81_8000, 32'h477f_f000, 32'h477f_efff, 32'h4780_0000, 32'h3880_0000,
        32'h3380_0000, 32'h3300_0000, 32'h32ff_ffff, 32'hb87f_f000, 32'h3f80_1000,
        32'h4770_0000, 32'h7f7f_ffff, 32'h0080_0000
    };

    fmt_t phase_formats[] = '{FMT_HALF, FMT_BF16, FMT_RSVD, FMT_PASS, FMT_HALF, FMT_BF16};

    initial begin
        in_ch.valid = 1'b0;
        in_ch.value_bits = '0;
        cfg.valid = 1'b0;
        cfg.data = FMT_PASS;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset format, then each format in turn.
        foreach (edge_words[i])
            send_word(edge_words[i]);
        foreach (phase_formats[p]) begin
            write_format(phase_formats[p]);
            if (p < 3)
                foreach (edge_words[i])
                    send_word(edge_words[i]);
            // One phase runs back-to-back with the receiver always ready.
            no_gaps = (p == 4);
            for (int k = 0; k < 240; k++) begin
                send_word(random_word());
                // A hold-off until every result is in, once mid-phase.
                if (p == 1 && k == 100)
                    drain();
            end
            no_gaps = 1'b0;
        end

        drain();
        if (quant_board.mismatches == 0 && quant_board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
src/spq_pkg.sv
src/spq_stream_if.sv
src/storage_precision_quantizer.sv
tb/sv/spq_tb_scoreboard.sv
tb/sv/tb.sv
